@@ rtl/mtdl_pkg.sv @@
// Package for the two-list descending merge block.
// Holds field widths, result kind codes, the register index and the
// command/status structs shared by controller, datapath and top level.
`default_nettype none

package mtdl_pkg;

  localparam int VALUE_W   = 32;
  localparam int KIND_W    = 2;
  localparam int POS_W     = 6;
  localparam int LEN_CFG_W = 6;
  localparam int PDATA_W   = 32;
  localparam int PADDR_W   = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACCEPT = 2'd0,
    KIND_REJECT = 2'd1,
    KIND_SORTED = 2'd2
  } kind_e;

  // Register index of list_length in the register file.
  localparam logic REG_LIST_LENGTH = 1'b0;

  // Controller to datapath.
  typedef struct packed {
    logic load;   // input transfer this cycle
    logic fetch;  // read both list heads
    logic emit;   // pick the larger head and load the output register
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic load_done;  // the current input completes list two
    logic last_pick;  // the current pick is the final burst value
  } sts_t;

endpackage

`default_nettype wire

@@ rtl/mtdl_ctrl.sv @@
// Controller for the two-list descending merge block.
// Sequences loading, head fetch and emit; uses mtdl_pkg.
`default_nettype none

module mtdl_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire mtdl_pkg::sts_t sts_i,
  output mtdl_pkg::cmd_t     cmd_o
);
  import mtdl_pkg::*;

  localparam logic [1:0] S_LOAD  = 2'd0;
  localparam logic [1:0] S_FETCH = 2'd1;
  localparam logic [1:0] S_EMIT  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       produce;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_LOAD) && out_free;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    produce     = 1'b0;
    case (state_q)
      S_LOAD: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.load = 1'b1;
          if (sts_i.load_done) begin
            state_d = S_FETCH;
          end else begin
            produce = 1'b1;
          end
        end
      end
      S_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          cmd_o.emit = 1'b1;
          produce    = 1'b1;
          state_d    = sts_i.last_pick ? S_LOAD : S_FETCH;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  // Hold the result until the transfer, refill when a new one is produced.
  assign out_valid_d = (out_valid_q && !out_ready_i) || produce;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_ready_only_loading: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == S_LOAD)
    else $error("input ready outside loading");

  a_done_starts_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load && sts_i.load_done) |=> state_q == S_FETCH && !in_ready_o)
    else $error("completed load did not start the burst");

  a_fetch_then_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FETCH |=> state_q == S_EMIT)
    else $error("fetch not followed by emit");

  a_last_back_to_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && sts_i.last_pick) |=> state_q == S_LOAD && out_valid_o)
    else $error("final pick did not return to loading");

endmodule

`default_nettype wire

@@ rtl/mtdl_dpath.sv @@
// Datapath for the two-list descending merge block: value store, load
// counter, merge pointers and output register; uses mtdl_pkg.
`default_nettype none

module mtdl_dpath #(
  parameter int MAX_LIST_LENGTH = 32
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic [$clog2(MAX_LIST_LENGTH+1)-1:0] len_i,
  input  wire logic                                 cfg_clr_i,
  input  wire logic signed [mtdl_pkg::VALUE_W-1:0]  value_i,
  input  wire mtdl_pkg::cmd_t                       cmd_i,
  output mtdl_pkg::sts_t                            sts_o,
  output logic [mtdl_pkg::KIND_W-1:0]               kind_o,
  output logic signed [mtdl_pkg::VALUE_W-1:0]       sorted_value_o,
  output logic [mtdl_pkg::POS_W-1:0]                position_o,
  output logic                                      last_o
);
  import mtdl_pkg::*;

  localparam int LEN_W  = $clog2(MAX_LIST_LENGTH + 1);
  localparam int TOT_W  = LEN_W + 1;
  localparam int DEPTH  = 2 * MAX_LIST_LENGTH;
  localparam int ADDR_W = $clog2(DEPTH);

  logic signed [VALUE_W-1:0] mem_q [DEPTH];

  logic [TOT_W-1:0]          count_q, count_d;
  logic [TOT_W-1:0]          ptr_a_q, ptr_b_q, k_q;
  logic signed [VALUE_W-1:0] prev_q;
  logic signed [VALUE_W-1:0] rd_a_q, rd_b_q;

  kind_e                     kind_q;
  logic signed [VALUE_W-1:0] value_q;
  logic [POS_W-1:0]          pos_q;
  logic                      last_q;

  logic [TOT_W-1:0] len_ext;
  logic [TOT_W-1:0] total;
  logic [TOT_W-1:0] count_eff;
  logic [TOT_W-1:0] count_inc;
  logic             list_start;
  logic             reject;
  logic             take_a;
  logic [TOT_W-1:0] k_inc;

  assign len_ext    = {1'b0, len_i};
  assign total      = {len_i, 1'b0};
  assign list_start = (count_q == '0) || (count_q == len_ext);
  assign count_eff  = (count_q >= total) ? '0 : count_q;
  assign count_inc  = count_eff + 1'b1;
  assign reject     = !list_start && (value_i > prev_q);

  assign sts_o.load_done = !reject && (count_inc == total);

  // Larger head wins; ties and an exhausted list two take list one.
  assign take_a = (ptr_b_q >= total) ||
                  ((ptr_a_q < len_ext) && !(rd_b_q > rd_a_q));
  assign k_inc  = k_q + 1'b1;
  assign sts_o.last_pick = (k_inc == total);

  always_comb begin
    count_d = count_q;
    if (cfg_clr_i) begin
      count_d = '0;
    end else if (cmd_i.load && !reject) begin
      count_d = sts_o.load_done ? '0 : count_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Store: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !reject) begin
      mem_q[count_eff[ADDR_W-1:0]] <= value_i;
    end
    if (cmd_i.fetch) begin
      rd_a_q <= mem_q[ptr_a_q[ADDR_W-1:0]];
      rd_b_q <= mem_q[ptr_b_q[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !reject) begin
      prev_q <= value_i;
    end
    if (cmd_i.load && sts_o.load_done) begin
      ptr_a_q <= '0;
      ptr_b_q <= len_ext;
      k_q     <= '0;
    end else if (cmd_i.emit) begin
      if (take_a) begin
        ptr_a_q <= ptr_a_q + 1'b1;
      end else begin
        ptr_b_q <= ptr_b_q + 1'b1;
      end
      k_q <= k_inc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !sts_o.load_done) begin
      kind_q  <= reject ? KIND_REJECT : KIND_ACCEPT;
      value_q <= '0;
      pos_q   <= '0;
      last_q  <= 1'b0;
    end else if (cmd_i.emit) begin
      kind_q  <= KIND_SORTED;
      value_q <= take_a ? rd_a_q : rd_b_q;
      pos_q   <= POS_W'(k_q);
      last_q  <= sts_o.last_pick;
    end
  end

  assign kind_o         = kind_q;
  assign sorted_value_o = value_q;
  assign position_o     = pos_q;
  assign last_o         = last_q;

endmodule

`default_nettype wire

@@ rtl/merge_two_descending_lists_top.sv @@
// Top level of the two-list descending merge block: APB register file,
// length clamp, and the mtdl_ctrl / mtdl_dpath pair; uses mtdl_pkg.
// Non-final load items give their result in the cycle after the transfer;
// one load item per cycle while the output is free; the final item starts a
// burst of 2*L sorted values, each a store read, then compare and register.
// Reset: list_length is 1 and loading starts empty; the value store has no
// reset and needs no clearing pass, a burst uses only entries of its load.
`default_nettype none

module merge_two_descending_lists_top #(
  parameter int MAX_LIST_LENGTH = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [mtdl_pkg::PADDR_W-1:0]        paddr,
  input  wire logic [mtdl_pkg::PDATA_W-1:0]        pwdata,
  output logic [mtdl_pkg::PDATA_W-1:0]             prdata,
  output logic                                     pready,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic signed [mtdl_pkg::VALUE_W-1:0] value_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [mtdl_pkg::KIND_W-1:0]              kind_o,
  output logic signed [mtdl_pkg::VALUE_W-1:0]      sorted_value_o,
  output logic [mtdl_pkg::POS_W-1:0]               position_o,
  output logic                                     last_o
);
  import mtdl_pkg::*;

  localparam int LEN_W = $clog2(MAX_LIST_LENGTH + 1);

  logic [LEN_CFG_W-1:0] len_q;
  logic                 reg_sel;
  logic                 cfg_wr;
  logic [LEN_CFG_W:0]   len_raw;
  logic [LEN_CFG_W:0]   len_clamp;
  logic [LEN_W-1:0]     len_eff;
  cmd_t                 cmd;
  sts_t                 sts;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[PADDR_W-1] == REG_LIST_LENGTH);
  assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;
  assign prdata  = reg_sel ? PDATA_W'(len_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LEN_CFG_W'(1);
    end else if (cfg_wr) begin
      len_q <= pwdata[LEN_CFG_W-1:0];
    end
  end

  // Raise zero to one, lower anything above the maximum to it.
  assign len_raw   = {1'b0, len_q};
  assign len_clamp = (len_raw == '0) ? (LEN_CFG_W+1)'(1) :
                     (len_raw > (LEN_CFG_W+1)'(MAX_LIST_LENGTH)) ?
                     (LEN_CFG_W+1)'(MAX_LIST_LENGTH) : len_raw;
  assign len_eff   = len_clamp[LEN_W-1:0];

  mtdl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mtdl_dpath #(
    .MAX_LIST_LENGTH (MAX_LIST_LENGTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .len_i          (len_eff),
    .cfg_clr_i      (cfg_wr),
    .value_i        (value_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .kind_o         (kind_o),
    .sorted_value_o (sorted_value_o),
    .position_o     (position_o),
    .last_o         (last_o)
  );

endmodule

`default_nettype wire
